// ===== design/afr_pkg.sv =====
package afr_pkg;

    localparam logic [7:0] START_DELIM = 8'h7E;
    localparam logic [7:0] GOOD_SUM    = 8'hFF;
    localparam int         NUM_STORED  = 7;

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LEN_HI = 5'b00010,
        PH_LEN_LO = 5'b00100,
        PH_DATA   = 5'b01000,
        PH_CSUM   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic                             frame_good;
        logic [7:0]                       length_low;
        logic [NUM_STORED-1:0][7:0]       bytes;
    } result_t;

endpackage

// ===== design/afr_parser.sv =====
module afr_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             beat,
    input  logic [7:0]       rx_byte,
    output logic             csum_phase,
    output logic             res_load,
    output afr_pkg::result_t res
);
    import afr_pkg::*;

    phase_t                     phase_reg, phase_next;
    logic [7:0]                 cnt_reg, cnt_next;
    logic [7:0]                 len_reg, len_next;
    logic [7:0]                 sum_reg, sum_next;
    logic [NUM_STORED-1:0][7:0] bytes_reg, bytes_next;
    logic [2:0]                 idx;

    assign idx = 3'(cnt_reg - 8'd1);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        bytes_next = bytes_reg;
        case (phase_reg)
            PH_LEN_HI:
            begin
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next   = rx_byte;
                phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (cnt_reg inside {[8'd1:8'd7]})
                begin
                    bytes_next[idx] = rx_byte;
                    sum_next        = sum_reg + rx_byte;
                end
                if (cnt_reg >= len_reg)
                    phase_next = PH_CSUM;
                if (cnt_reg != 8'hFF)
                    cnt_next = cnt_reg + 8'd1;
            end
            PH_CSUM:
            begin
                phase_next = PH_HUNT;
            end
            default:
            begin
                if (rx_byte == START_DELIM)
                begin
                    bytes_next = '0;
                    sum_next   = 8'd0;
                    len_next   = 8'd0;
                    cnt_next   = 8'd1;
                    phase_next = PH_LEN_HI;
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= 8'd1;
            len_reg   <= 8'd0;
            sum_reg   <= 8'd0;
            bytes_reg <= '0;
        end
        else if (beat)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            bytes_reg <= bytes_next;
        end
    end

    assign csum_phase     = (phase_reg == PH_CSUM);
    assign res_load       = beat && csum_phase;
    assign res.frame_good = ((sum_reg + rx_byte) == GOOD_SUM);
    assign res.length_low = len_reg;
    assign res.bytes      = bytes_reg;

endmodule

// ===== design/afr_out_reg.sv =====
module afr_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  afr_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output afr_pkg::result_t out_res
);
    import afr_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== design/api_frame_receiver_core.sv =====
// Serial API frame receiver. Takes one received byte per beat on rx_byte and
// emits one result beat per frame (delimiter, two length bytes, data, checksum)
// when its checksum byte arrives; data bytes past the seventh are counted only.
// A byte is taken every cycle unless in_ready drops, which happens only when the
// checksum byte is presented while the previous result waits in the output
// register; the result appears on out_valid the cycle after the checksum beat.
module api_frame_receiver_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       frame_good,
    output logic [7:0] length_low,
    output logic [7:0] api_id,
    output logic [7:0] data_one,
    output logic [7:0] data_two,
    output logic [7:0] data_three,
    output logic [7:0] data_four,
    output logic [7:0] data_five,
    output logic [7:0] data_six
);
    import afr_pkg::*;

    logic       beat;
    logic       csum_phase;
    logic       res_load;
    result_t    res;
    result_t    out_res;

    assign in_ready = !(csum_phase && out_valid && !out_ready);
    assign beat     = in_valid && in_ready;

    afr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .rx_byte    (rx_byte),
        .csum_phase (csum_phase),
        .res_load   (res_load),
        .res        (res)
    );

    afr_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign frame_good = out_res.frame_good;
    assign length_low = out_res.length_low;
    assign api_id     = out_res.bytes[0];
    assign data_one   = out_res.bytes[1];
    assign data_two   = out_res.bytes[2];
    assign data_three = out_res.bytes[3];
    assign data_four  = out_res.bytes[4];
    assign data_five  = out_res.bytes[5];
    assign data_six   = out_res.bytes[6];

endmodule

// ===== design/afr_checker.sv =====
module afr_assert (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       frame_good,
    input logic [7:0] length_low,
    input logic [7:0] api_id,
    input logic [7:0] data_one,
    input logic [7:0] data_two,
    input logic [7:0] data_three,
    input logic [7:0] data_four,
    input logic [7:0] data_five,
    input logic [7:0] data_six
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({frame_good, length_low, api_id, data_one,
            data_two, data_three, data_four, data_five, data_six}))
        else $error("result payload changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_result_from_beat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result appeared without an input beat");

endmodule

bind api_frame_receiver_core afr_assert u_afr_assert (.*);
